// ----- src/smao_pkg.sv -----
package smao_pkg;

   localparam int STACK_DEPTH = 64;              // entries held by the cell row
   localparam int WORD_W      = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DEPTH_W     = 7;               // stack_depth field on the result
   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int STEP_W      = $clog2(WORD_W);
   localparam int RSP_DATA_W  = ((WORD_W + DEPTH_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - WORD_W - DEPTH_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_NOP  = 3'd0,
      CMD_PUSH = 3'd1,
      CMD_SWAP = 3'd2,
      CMD_ADD  = 3'd3,
      CMD_SUB  = 3'd4,
      CMD_DIV  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_DIVZERO = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // what a cell loads at the next edge
   typedef enum logic [1:0] {
      CM_HOLD = 2'd0,
      CM_PREV = 2'd1,   // from the neighbor nearer the top (push)
      CM_NEXT = 2'd2,   // from the neighbor farther from the top (pop)
      CM_LOAD = 2'd3    // from load_data
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type     mode;
      logic [WORD_W-1:0] load_data;
   } cell_ctl_type;

endpackage

// ----- src/smao_cell.sv -----
module smao_cell
   import smao_pkg::*;
(
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [WORD_W-1:0] prev_data,
   input  logic [WORD_W-1:0] next_data,
   output logic [WORD_W-1:0] data_ff
);

   logic [WORD_W-1:0] data_in;

   always_comb begin
      case (ctl.mode)
         CM_HOLD: data_in = data_ff;
         CM_PREV: data_in = prev_data;
         CM_NEXT: data_in = next_data;
         CM_LOAD: data_in = ctl.load_data;
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ----- src/smao_div.sv -----
module smao_div
   import smao_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] num,
   input  logic [WORD_W-1:0] den,
   output logic              busy_ff,
   output logic [WORD_W-1:0] quotient
);

   // restoring division on magnitudes, one quotient bit per cycle
   logic              busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dmag_ff, dmag_in;
   logic              neg_ff, neg_in;
   logic [WORD_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[WORD_W-1]} - {1'b0, dmag_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(WORD_W - 1);
         rem_in  = '0;
         quo_in  = num[WORD_W-1] ? (~num + 1'b1) : num;
         dmag_in = den[WORD_W-1] ? (~den + 1'b1) : den;
         neg_in  = num[WORD_W-1] ^ den[WORD_W-1];
      end else if (busy_ff) begin
         if (!trial[WORD_W]) begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   // min / -1 gives magnitude 2^31 with no negate: wraps to min as required
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

endmodule

// ----- src/stack_machine_alu_ops.sv -----
// Channel | Dir | Handshake           | Payload
// req     | in  | req_tvalid/tready   | tuser: cmd[2:0]; tdata: push_value[31:0]
// rsp     | out | rsp_tvalid/tready   | tdata: top_value[31:0], stack_depth[38:32], pad;
//         |     |                     | tuser: status[1:0]
//
// nop, push, swap, add, sub and error cases: the result is registered in the cycle after the transfer in.
// div: transfer, 32 quotient-bit steps in smao_div, then commit to the cells once the output is free.
// The stack is a row of cells with the top in cell 0; push and pop shift the row by one.
// Reset (synchronous, active high) clears the entry count, FSM and result valid;
// cell contents are left as they are.
// A result waits in the output register; a new command is taken once it is taken or
// in the same cycle that it is taken.
module stack_machine_alu_ops
   import smao_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [WORD_W-1:0]     req_tdata,   // [31:0] push_value
   input  logic [CMD_W-1:0]      req_tuser,   // [2:0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] top_value, [38:32] stack_depth, zero pad
   output logic [STATUS_W-1:0]   rsp_tuser    // [1:0] status
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DIV  = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_top_ff, rsp_top_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   status_type        rsp_status_ff, rsp_status_in;

   cell_ctl_type      cell_ctl [STACK_DEPTH];
   logic [WORD_W-1:0] cell_data [STACK_DEPTH];

   cell_mode_type     mode0, mode1, mode_rest;
   logic [WORD_W-1:0] load0, load1;

   cmd_type           cmd;
   logic              accept, out_free, out_load;
   logic              has_two, full;
   logic [WORD_W-1:0] top_w, sec_w, sum_w, diff_w;
   logic              div_start, div_busy;
   logic [WORD_W-1:0] div_quot;

   // ---------------- cell row: cell 0 is the top of stack
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] prev_w, next_w;
      if (i == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_mid_prev
         assign prev_w = cell_data[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_mid_next
         assign next_w = cell_data[i+1];
      end
      if (i == 0) begin : g_ctl0
         assign cell_ctl[i] = '{mode: mode0, load_data: load0};
      end else if (i == 1) begin : g_ctl1
         assign cell_ctl[i] = '{mode: mode1, load_data: load1};
      end else begin : g_ctln
         assign cell_ctl[i] = '{mode: mode_rest, load_data: '0};
      end
      smao_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .prev_data (prev_w),
         .next_data (next_w),
         .data_ff   (cell_data[i])
      );
   end

   // ---------------- divider, shared by every div command
   smao_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (sec_w),
      .den      (top_w),
      .busy_ff  (div_busy),
      .quotient (div_quot)
   );

   assign cmd        = cmd_type'(req_tuser);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign top_w   = cell_data[0];
   assign sec_w   = cell_data[1];
   assign sum_w   = sec_w + top_w;
   assign diff_w  = sec_w - top_w;
   assign has_two = count_ff >= CNT_W'(2);
   assign full    = count_ff == CNT_W'(STACK_DEPTH);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      mode0         = CM_HOLD;
      mode1         = CM_HOLD;
      mode_rest     = CM_HOLD;
      load0         = '0;
      load1         = '0;
      div_start     = 1'b0;
      out_load      = 1'b0;
      rsp_top_in    = (count_ff == '0) ? '0 : top_w;
      rsp_cnt_in    = count_ff;
      rsp_status_in = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               out_load = 1'b1;
               case (cmd)
                  CMD_PUSH: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mode0      = CM_LOAD;
                        load0      = req_tdata;
                        mode1      = CM_PREV;
                        mode_rest  = CM_PREV;
                        count_in   = count_ff + 1'b1;
                        rsp_top_in = req_tdata;
                        rsp_cnt_in = count_ff + 1'b1;
                     end
                  end
                  CMD_SWAP: begin
                     if (!has_two) begin
                        rsp_status_in = ST_SHORT;
                     end else begin
                        mode0      = CM_LOAD;
                        load0      = sec_w;
                        mode1      = CM_LOAD;
                        load1      = top_w;
                        rsp_top_in = sec_w;
                     end
                  end
                  CMD_ADD, CMD_SUB: begin
                     if (!has_two) begin
                        rsp_status_in = ST_SHORT;
                     end else begin
                        mode0      = CM_LOAD;
                        load0      = (cmd == CMD_ADD) ? sum_w : diff_w;
                        mode1      = CM_NEXT;
                        mode_rest  = CM_NEXT;
                        count_in   = count_ff - 1'b1;
                        rsp_top_in = load0;
                        rsp_cnt_in = count_ff - 1'b1;
                     end
                  end
                  CMD_DIV: begin
                     if (!has_two) begin
                        rsp_status_in = ST_SHORT;
                     end else if (top_w == '0) begin
                        rsp_status_in = ST_DIVZERO;
                     end else begin
                        // result comes at commit, after the divider finishes
                        out_load  = 1'b0;
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                     // nop and unused codes: report the stack as it stands
                  end
               endcase
            end
         end
         S_DIV: begin
            if (!div_busy && out_free) begin
               out_load   = 1'b1;
               mode0      = CM_LOAD;
               load0      = div_quot;
               mode1      = CM_NEXT;
               mode_rest  = CM_NEXT;
               count_in   = count_ff - 1'b1;
               rsp_top_in = div_quot;
               rsp_cnt_in = count_ff - 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_top_ff    <= rsp_top_in;
         rsp_cnt_ff    <= rsp_cnt_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, DEPTH_W'(rsp_cnt_ff), rsp_top_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- src/smao_checker.sv -----
module smao_checker
   import smao_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   logic [DEPTH_W-1:0] depth_w;
   logic [WORD_W-1:0]  top_w;

   assign depth_w = rsp_tdata[WORD_W +: DEPTH_W];
   assign top_w   = rsp_tdata[WORD_W-1:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a pending result blocks the next command
   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("command taken while result stalled");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(depth_w) <= STACK_DEPTH)
      else $error("stack depth beyond capacity");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && depth_w == '0 |-> top_w == '0)
      else $error("empty stack with nonzero top");

endmodule

bind stack_machine_alu_ops smao_checker u_smao_checker (.*);
